// File: hdl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants for the k-th smallest select core
// Word layouts of both channels, datapath op codes and the status group.
// ----------------------------------------------------------------------------
package kss_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned RANK_W  = 11;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic        [RANK_W-1:0]  select_rank;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] kth_value;
		logic                      rank_invalid;
		logic                      overflow;
	} result_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_WIN_INIT,
		OP_PIV_RD,
		OP_PIV_SET,
		OP_SCAN_RD,
		OP_SWAP_LO,
		OP_SWAP_HI,
		OP_SKIP,
		OP_FIN,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic rank_bad;
		logic j_at_hi;
		logic le;
		logic hit;
	} status_t;

endpackage

// File: hdl/kth_smallest_select_core.sv
// ----------------------------------------------------------------------------
// kth_smallest_select_core: k-th smallest of a loaded set by quickselect
// Loads signed words into an element memory, then selects by partitioning.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle. After the word marked last, the core checks
// the rank, then runs Lomuto partition passes over a shrinking window of the
// element memory; each pass fetches and places the pivot, reads and compares
// each element scanned and writes a swap for each one at or below the pivot,
// with the two writes of a swap in separate steps, bounded by the memory's
// single write port, and ends with the closing read and the window update.
// A result state then hands the result off. Worst-case selection time grows
// with the square of the set size. No input word is taken during selection.
// A result word may wait on the output while the next set loads. An invalid
// rank returns the largest signed value with rank_invalid set; words beyond
// MAX_ELEMENTS are dropped and reported through overflow.
module kth_smallest_select_core #(
	parameter int unsigned MAX_ELEMENTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  kss_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output kss_pkg::result_t result
);
	import kss_pkg::*;

	cmd_t    cmd;
	status_t status;

	kss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_last    (item.last),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	kss_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

// File: hdl/kss_dp.sv
// ----------------------------------------------------------------------------
// kss_dp: element store and partition datapath
// Holds the element memory, window bounds, scan pointers and result register.
// ----------------------------------------------------------------------------
module kss_dp #(
	parameter int unsigned MAX_ELEMENTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kss_pkg::cmd_t    cmd,
	input  kss_pkg::item_t   item,
	output kss_pkg::status_t status,
	output kss_pkg::result_t result
);
	import kss_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ELEMENTS);
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned MW = (CW > RANK_W) ? CW : RANK_W;

	logic [VALUE_W-1:0] mem [MAX_ELEMENTS];

	logic [CW-1:0]      count_q;
	logic               dropped_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      j_q;
	logic [RANK_W-1:0]  rank_q;
	logic [VALUE_W-1:0] pivot_q;
	logic [VALUE_W-1:0] rd_a_q;
	logic [VALUE_W-1:0] rd_b_q;
	result_t            result_q;

	logic               full;
	logic [AW-1:0]      mid;
	logic [AW-1:0]      offset;
	logic [MW-1:0]      rank_m1;
	logic               gt;
	logic [AW-1:0]      addr_a;
	logic [AW-1:0]      addr_b;
	logic               rd_en;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;

	assign full    = (count_q == CW'(MAX_ELEMENTS));
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign offset  = i_q - lo_q;
	assign rank_m1 = MW'(rank_q) - MW'(1);
	assign gt      = (MW'(offset) > rank_m1);

	assign status.rank_bad = (rank_q == '0) || (MW'(rank_q) > MW'(count_q));
	assign status.j_at_hi  = (j_q == hi_q);
	assign status.le       = ($signed(rd_a_q) <= $signed(pivot_q));
	assign status.hit      = (MW'(offset) == rank_m1);

	assign result = result_q;

	// port a reads the scanned entry, port b the entry under i; the pivot fetch reads mid and hi
	always_comb begin
		addr_a  = j_q;
		addr_b  = i_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd_a_q;
		case (cmd.op)
			OP_LOAD: begin
				wr_en   = !full;
				wr_addr = count_q[AW-1:0];
				wr_data = item.value;
			end
			OP_PIV_RD: begin
				rd_en  = 1'b1;
				addr_a = mid;
				addr_b = hi_q;
			end
			OP_PIV_SET: begin
				// pivot lives in a register; old hi entry fills the hole at mid
				wr_en   = 1'b1;
				wr_addr = mid;
				wr_data = rd_b_q;
			end
			OP_SCAN_RD: begin
				rd_en = 1'b1;
			end
			OP_SWAP_LO: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rd_a_q;
			end
			OP_SWAP_HI: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = rd_b_q;
			end
			OP_FIN: begin
				// entry at i moves to hi; pivot's own slot is never read again
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = rd_b_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			rank_q    <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
					if (item.last) begin
						rank_q <= item.select_rank;
					end
				end
				OP_WIN_INIT: begin
					lo_q <= '0;
					hi_q <= AW'(count_q - CW'(1));
				end
				OP_PIV_SET: begin
					i_q <= lo_q;
					j_q <= lo_q;
				end
				OP_SWAP_HI: begin
					i_q <= i_q + AW'(1);
					j_q <= j_q + AW'(1);
				end
				OP_SKIP: begin
					j_q <= j_q + AW'(1);
				end
				OP_FIN: begin
					if (gt) begin
						hi_q <= i_q - AW'(1);
					end else if (!status.hit) begin
						rank_q <= RANK_W'(rank_m1 - MW'(offset));
						lo_q   <= i_q + AW'(1);
					end
				end
				OP_RESULT: begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					lo_q      <= '0;
					hi_q      <= '0;
					rank_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PIV_SET) begin
			pivot_q <= rd_a_q;
		end
		if (cmd.op == OP_RESULT) begin
			result_q.kth_value    <= status.rank_bad ? VALUE_MAX : pivot_q;
			result_q.rank_invalid <= status.rank_bad;
			result_q.overflow     <= dropped_q;
		end
	end

`ifndef SYNTHESIS
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SCAN_RD) |-> (i_q <= j_q) && (j_q <= hi_q))
		else $error("scan pointers out of order");

	a_window_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PIV_RD) |-> (lo_q <= hi_q))
		else $error("empty partition window");

	a_rank_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PIV_RD) |-> (rank_q != '0) && (rank_m1 <= MW'(hi_q - lo_q)))
		else $error("remaining rank outside window");
`endif

endmodule

// File: hdl/kss_ctrl.sv
// ----------------------------------------------------------------------------
// kss_ctrl: sequencer for loading, partition passes and result hand-off
// Issues one datapath op per cycle and owns the output word valid.
// ----------------------------------------------------------------------------
module kss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_last,
	output logic             item_stall,
	output logic             result_valid,
	input  logic             result_stall,
	input  kss_pkg::status_t status,
	output kss_pkg::cmd_t    cmd
);
	import kss_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_PIV_RD,
		ST_PIV_SET,
		ST_SCAN_RD,
		ST_CMP,
		ST_SWAP,
		ST_FIN,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_LOAD);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			ST_LOAD:    cmd.op = item_valid ? OP_LOAD : OP_NONE;
			ST_CHECK:   cmd.op = status.rank_bad ? OP_NONE : OP_WIN_INIT;
			ST_PIV_RD:  cmd.op = OP_PIV_RD;
			ST_PIV_SET: cmd.op = OP_PIV_SET;
			ST_SCAN_RD: cmd.op = OP_SCAN_RD;
			ST_CMP:     cmd.op = status.le ? OP_SWAP_LO : OP_SKIP;
			ST_SWAP:    cmd.op = OP_SWAP_HI;
			ST_FIN:     cmd.op = OP_FIN;
			ST_RESULT:  cmd.op = out_free ? OP_RESULT : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (item_valid && item_last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.rank_bad ? ST_RESULT : ST_PIV_RD;
				end
				ST_PIV_RD:  state_q <= ST_PIV_SET;
				ST_PIV_SET: state_q <= ST_SCAN_RD;
				ST_SCAN_RD: begin
					// last read of a pass also fetches the entry under i
					state_q <= status.j_at_hi ? ST_FIN : ST_CMP;
				end
				ST_CMP: begin
					state_q <= status.le ? ST_SWAP : ST_SCAN_RD;
				end
				ST_SWAP: state_q <= ST_SCAN_RD;
				ST_FIN: begin
					state_q <= status.hit ? ST_RESULT : ST_PIV_RD;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESULT) |-> (!out_valid_q || !result_stall))
		else $error("result word overwritten while stalled");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RESULT) |=> out_valid_q && (state_q == ST_LOAD))
		else $error("result word not presented after hand-off");

	a_rise_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op == OP_RESULT))
		else $error("output word valid without a result");
`endif

endmodule

// File: tb/kth_smallest_select_core_tb.sv
// ----------------------------------------------------------------------------
// kth_smallest_select_core_tb: self-checking bench for the quickselect core
// Streams sets of signed words with a rank on the closing word and checks each
// result word against a rank-counting predictor. Covers edge values, invalid
// ranks, duplicates, a full store and dropped words, a long output hold-off,
// and a random mix of set sizes, with bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module kth_smallest_select_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kss_pkg::*;

	localparam int unsigned SET_CAP      = 1024;
	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned RANDOM_ITEMS = 380;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS} stall_mode_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// predictor state: the words of the set being loaded
	logic signed [VALUE_W-1:0] set_values[$];
	bit                        set_dropped = 1'b0;
	result_t                   expected_results[$];

	int error_count  = 0;
	int item_total   = 0;
	int gap_max      = 0;
	int burst_left   = 0;
	bit hold_off_req = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	kth_smallest_select_core #(
		.MAX_ELEMENTS(SET_CAP)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// k-th smallest: the value with fewer than k below it and at least k not above it
	function automatic logic signed [VALUE_W-1:0] kth_smallest_of_set(int unsigned rank);
		int unsigned below;
		int unsigned not_above;
		for (int i = 0; i < set_values.size(); i++) begin
			below = 0;
			not_above = 0;
			foreach (set_values[j]) begin
				if (set_values[j] < set_values[i])
					below++;
				if (set_values[j] <= set_values[i])
					not_above++;
			end
			if (below < rank && rank <= not_above)
				return set_values[i];
		end
		return '0;
	endfunction

	function automatic void absorb_word(item_t w);
		result_t r;
		if (set_values.size() < SET_CAP)
			set_values = {set_values, w.value};
		else
			set_dropped = 1'b1;
		if (w.last) begin
			if (w.select_rank == 0 || w.select_rank > set_values.size()) begin
				r.kth_value    = VALUE_MAX;
				r.rank_invalid = 1'b1;
			end else begin
				r.kth_value    = kth_smallest_of_set(w.select_rank);
				r.rank_invalid = 1'b0;
			end
			r.overflow = set_dropped;
			expected_results = {expected_results, r};
			set_values.delete();
			set_dropped = 1'b0;
		end
	endfunction

	function automatic logic signed [VALUE_W-1:0] draw_value(spread_t spread);
		case (spread)
			SPREAD_FULL: return $urandom;
			SPREAD_NARROW: return $signed($urandom_range(8)) - 4;
			default: begin
				case ($urandom_range(3))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic is_last,
			input logic [RANK_W-1:0] rank);
		item_t w;
		w.value       = v;
		w.last        = is_last;
		w.select_rank = rank;
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		absorb_word(w);
		item_total++;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(gap_max, 1)) @(posedge clk);
				burst_left = $urandom_range(24, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	// rank on the words before the last is noise the core must ignore
	task automatic send_set(input int unsigned size, input logic [RANK_W-1:0] rank,
			input spread_t spread);
		for (int unsigned n = 1; n <= size; n++)
			send_word(draw_value(spread), n == size,
				n == size ? rank : RANK_W'($urandom_range(2047)));
	endtask

	task automatic test_edges();
		gap_max = 2;
		send_word(VALUE_MIN, 1'b0, '0);
		send_word(VALUE_MAX, 1'b0, '0);
		send_word('0, 1'b0, '0);
		send_word(-1, 1'b0, '0);
		send_word(1, 1'b1, RANK_W'(1));
		send_word(VALUE_MAX, 1'b0, '0);
		send_word(VALUE_MIN, 1'b1, RANK_W'(2));
		send_word(42, 1'b1, RANK_W'(1));
		repeat (3) send_word(7, 1'b0, '1);
		send_word(7, 1'b1, RANK_W'(3));
		// rank zero
		send_word(5, 1'b0, '0);
		send_word(-5, 1'b1, '0);
		// rank past the count
		send_word(1, 1'b0, '0);
		send_word(2, 1'b0, '0);
		send_word(3, 1'b1, RANK_W'(4));
		send_word(VALUE_MIN, 1'b1, RANK_W'(SET_CAP));
	endtask

	task automatic test_store_full();
		gap_max = 3;
		// store fills, then two more words drop, the last word among them;
		// the rank is the top one that is still valid
		send_set(SET_CAP + 2, RANK_W'(SET_CAP), SPREAD_FULL);
	endtask

	task automatic test_backpressure();
		int unsigned size;
		gap_max = 0;
		hold_off_req = 1'b1;
		repeat (8) begin
			size = $urandom_range(6, 1);
			send_set(size, RANK_W'($urandom_range(size, 1)), SPREAD_FULL);
		end
	endtask

	task automatic test_random();
		int          first;
		int unsigned size;
		int unsigned pick;
		spread_t     spread;
		logic [RANK_W-1:0] rank;
		first = item_total;
		while (item_total - first < RANDOM_ITEMS) begin
			gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			pick = $urandom_range(99);
			if (pick < 80)
				size = $urandom_range(12, 1);
			else if (pick < 97)
				size = $urandom_range(64, 13);
			else
				size = $urandom_range(300, 65);
			// heavy duplicates only on small sets, they drive the partition quadratic
			spread = (size <= 64) ? spread_t'($urandom_range(2)) : SPREAD_FULL;
			pick = $urandom_range(9);
			if (pick < 8)
				rank = RANK_W'($urandom_range(size, 1));
			else if (pick == 8)
				rank = '0;
			else
				rank = RANK_W'($urandom_range(SET_CAP, size + 1));
			send_set(size, rank, spread);
		end
	endtask

	initial begin : receiver
		stall_mode_t stall_mode;
		int unsigned mode_left;
		int unsigned hold_left;
		stall_mode = STALL_NONE;
		mode_left  = 0;
		hold_left  = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(3));
				mode_left  = $urandom_range(512, 64);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE: result_stall <= 1'b0;
					STALL_LIGHT: result_stall <= ($urandom_range(3) == 0);
					STALL_HEAVY: result_stall <= ($urandom_range(3) != 0);
					default: result_stall <= ((mode_left % 16) < 6);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word: kth_value %0d", result.kth_value);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.kth_value !== want.kth_value) begin
					$error("kth_value: expected %0d, got %0d", want.kth_value,
						result.kth_value);
					error_count++;
				end
				if (result.rank_invalid !== want.rank_invalid) begin
					$error("rank_invalid: expected %0b, got %0b", want.rank_invalid,
						result.rank_invalid);
					error_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow,
						result.overflow);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_store_full();
		test_backpressure();
		test_random();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("** kth_smallest_select_core: PASSED **");
		else
			$display("** kth_smallest_select_core: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** kth_smallest_select_core: FAILED **");
		$finish;
	end

endmodule
